/* rtl/lec_pkg.sv */
// Shared constants and types for the lower envelope conjugate block.
package lec_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int XY_W       = 32;
	localparam int DIFF_W     = XY_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int FRAC_W     = 16;
	localparam int DIVD_W     = DIFF_W + FRAC_W;
	localparam int STEP_W     = $clog2(DIVD_W + 1);

	localparam logic signed [XY_W-1:0] SAT_MAX = {1'b0, {(XY_W-1){1'b1}}};
	localparam logic signed [XY_W-1:0] SAT_MIN = {1'b1, {(XY_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_RD0,
		ST_RD1,
		ST_RDL,
		ST_VERT,
		ST_CRD,
		ST_CLD,
		ST_CMP,
		ST_VEND,
		ST_ERD,
		ST_ERD1,
		ST_ERD2,
		ST_DIV,
		ST_DWT,
		ST_MUL,
		ST_OFF
	} lec_state_t;

	// Control handshake between the sequencer and the divider.
	typedef struct packed {
		logic start;
	} lec_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lec_div_rsp_t;

endpackage

/* rtl/lower_envelope_conjugate_top.sv */
// Lower convex envelope by gift wrapping and its conjugate breakpoints.
// Wrapping is paced by the one-read-port sample memory and the shared multiplier;
// each breakpoint then waits on the bit-serial divider.
// Throughput: one sample per cycle while collecting; no sample is taken while wrapping or emitting breakpoints.
// Reset clears the sequencer, counters and output valid; memories are not cleared.
module lower_envelope_conjugate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // point_x [31:0], point_y [63:32]
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // conj_slope [31:0], conj_offset [63:32]
	output logic        m_tlast    // last_edge
);
	import lec_pkg::*;

	lec_state_t state_q, state_d;

	logic [CNT_W-1:0]  scnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  h_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  k_q;
	logic [2:0]        step_q;

	logic signed [XY_W-1:0] first_x_q, first_y_q, last_x_q;
	logic signed [XY_W-1:0] px_q, py_q, ex_q, ey_q, rx_q, ry_q;
	logic signed [DIFF_W-1:0] dqx_q, dqy_q, drx_q, dry_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  cross_q, dist_q;

	logic signed [XY_W-1:0]   x0_q, y0_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [XY_W-1:0]   slope_q;
	logic signed [2*XY_W-1:0] oprod_q;

	logic        out_valid_q, out_last_q;
	logic [63:0] out_data_q;

	// Memory ports.
	logic               s_we, h_we;
	logic [ADDR_W-1:0]  s_waddr, s_raddr, h_waddr, h_raddr;
	logic [2*XY_W-1:0]  s_rdata, h_rdata, h_wdata;

	lec_div_req_t div_req;
	lec_div_rsp_t div_rsp;
	logic [DIVD_W-1:0] div_q;
	logic [DIVD_W-1:0] div_dividend;
	logic [DIFF_W-1:0] div_divisor;

	logic              in_xfer;
	logic              out_free;
	logic [CNT_W-1:0]  scnt_inc;
	logic [CNT_W-1:0]  h_inc;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0]  dist_fin;
	logic              take_r;
	logic signed [XY_W-1:0]   rd_x, rd_y, hd_x, hd_y;
	logic                     q_neg;
	logic signed [XY_W-1:0]   slope_sat;
	logic signed [2*XY_W-1:0] oprod_adj;
	logic signed [2*XY_W-FRAC_W-1:0] otrunc;
	logic signed [2*XY_W-FRAC_W:0]   odiff;
	logic signed [XY_W-1:0]   offset_sat;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_COLLECT);
	assign out_free = !out_valid_q || m_tready;
	assign scnt_inc = scnt_q + 1'b1;
	assign h_inc    = h_q + 1'b1;
	assign rd_x     = s_rdata[XY_W-1:0];
	assign rd_y     = s_rdata[2*XY_W-1:XY_W];
	assign hd_x     = h_rdata[XY_W-1:0];
	assign hd_y     = h_rdata[2*XY_W-1:XY_W];

	lec_ram #(.WIDTH(2 * XY_W), .AW(ADDR_W)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_tdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	lec_ram #(.WIDTH(2 * XY_W), .AW(ADDR_W)) u_hull_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	lec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp),
		.quotient (div_q)
	);

	// Sample store writes while collecting; drops samples once full.
	assign s_we    = in_xfer && (scnt_q < CNT_W'(MAX_POINTS));
	assign s_waddr = scnt_q[ADDR_W-1:0];

	// Hull store is written once per envelope vertex.
	assign h_we    = (state_q == ST_VERT);
	assign h_waddr = h_q[ADDR_W-1:0];
	assign h_wdata = {py_q, px_q};

	// Sample read address follows the wrapping sequence.
	always_comb begin
		case (state_q)
			ST_RD1:  s_raddr = ADDR_W'(n_q - 1'b1);
			ST_CRD:  s_raddr = j_q[ADDR_W-1:0];
			default: s_raddr = '0;
		endcase
	end

	// Hull read address walks edge endpoints.
	always_comb begin
		case (state_q)
			ST_ERD1: h_raddr = ADDR_W'(k_q + 1'b1);
			default: h_raddr = k_q[ADDR_W-1:0];
		endcase
	end

	// Shared multiplier for the turn and distance terms.
	always_comb begin
		case (step_q)
			3'd0:    begin mul_a = dqx_q; mul_b = dry_q; end
			3'd1:    begin mul_a = drx_q; mul_b = dqy_q; end
			3'd2:    begin mul_a = drx_q; mul_b = drx_q; end
			3'd3:    begin mul_a = dry_q; mul_b = dry_q; end
			3'd4:    begin mul_a = dqx_q; mul_b = dqx_q; end
			default: begin mul_a = dqy_q; mul_b = dqy_q; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Keep the candidate if the current endpoint shares the pivot's x, if it turns clockwise, or is collinear and farther.
	assign dist_fin = dist_q - ACC_W'(prod_q);
	assign take_r = (ex_q == px_q) || cross_q[ACC_W-1] ||
		((cross_q == '0) && !dist_fin[ACC_W-1] && (dist_fin != '0));

	// Divider operands are magnitudes; the sign is restored afterwards.
	assign div_dividend = {(dy_q[DIFF_W-1] ? -dy_q : dy_q), {FRAC_W{1'b0}}};
	assign div_divisor  = dx_q[DIFF_W-1] ? -dx_q : dx_q;
	assign div_req.start = (state_q == ST_DIV) && (dx_q != '0);

	// Signed, saturated slope from the quotient magnitude.
	assign q_neg = dx_q[DIFF_W-1] ^ dy_q[DIFF_W-1];
	always_comb begin
		if (!q_neg) begin
			slope_sat = (div_q > DIVD_W'(SAT_MAX)) ? SAT_MAX : XY_W'(div_q);
		end else if (div_q > {{(DIVD_W-XY_W){1'b0}}, SAT_MIN}) begin
			slope_sat = SAT_MIN;
		end else begin
			slope_sat = XY_W'(-div_q);
		end
	end

	// Offset: product truncated toward zero by the fraction, minus y, saturated.
	assign oprod_adj = oprod_q[2*XY_W-1] ?
		oprod_q + (2*XY_W)'((1 << FRAC_W) - 1) : oprod_q;
	assign otrunc = oprod_adj[2*XY_W-1:FRAC_W];
	assign odiff  = {otrunc[2*XY_W-FRAC_W-1], otrunc} - (2*XY_W-FRAC_W+1)'(y0_q);
	always_comb begin
		if (!odiff[2*XY_W-FRAC_W] && (odiff > (2*XY_W-FRAC_W+1)'(SAT_MAX))) begin
			offset_sat = SAT_MAX;
		end else if (odiff[2*XY_W-FRAC_W] && (odiff < (2*XY_W-FRAC_W+1)'(SAT_MIN))) begin
			offset_sat = SAT_MIN;
		end else begin
			offset_sat = XY_W'(odiff);
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (in_xfer && s_tlast) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_RDL;
			ST_RDL: state_d = ST_VERT;
			ST_VERT: begin
				if ((px_q == last_x_q) || (h_inc >= CNT_W'(MAX_POINTS))) begin
					state_d = ST_ERD;
				end else if (n_q > CNT_W'(1)) begin
					state_d = ST_CRD;
				end else begin
					state_d = ST_VEND;
				end
			end
			ST_CRD: state_d = ST_CLD;
			ST_CLD: state_d = ST_CMP;
			ST_CMP: begin
				if (step_q == 3'd6) begin
					state_d = ((j_q + 1'b1) < n_q) ? ST_CRD : ST_VEND;
				end
			end
			ST_VEND: state_d = (ex_q == first_x_q) ? ST_ERD : ST_VERT;
			ST_ERD:  state_d = ((k_q + 1'b1) >= h_q) ? ST_COLLECT : ST_ERD1;
			ST_ERD1: state_d = ST_ERD2;
			ST_ERD2: state_d = ST_DIV;
			ST_DIV:  state_d = (dx_q == '0) ? ST_MUL : ST_DWT;
			ST_DWT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_OFF;
			ST_OFF: begin
				if (out_free) begin
					state_d = ST_ERD;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	// Counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
			n_q    <= '0;
			h_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (in_xfer) begin
						if (s_tlast) begin
							n_q    <= s_we ? scnt_inc : scnt_q;
							scnt_q <= '0;
						end else if (s_we) begin
							scnt_q <= scnt_inc;
						end
					end
				end
				ST_RDL:  h_q <= '0;
				ST_VERT: begin
					h_q <= h_inc;
					j_q <= CNT_W'(1);
					k_q <= '0;
				end
				ST_CLD:  step_q <= '0;
				ST_CMP: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd6) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_VEND: k_q <= '0;
				ST_OFF: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Wrapping datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD1: begin
				first_x_q <= rd_x;
				first_y_q <= rd_y;
			end
			ST_RDL: begin
				last_x_q <= rd_x;
				px_q     <= first_x_q;
				py_q     <= first_y_q;
			end
			ST_VERT: begin
				ex_q <= first_x_q;
				ey_q <= first_y_q;
			end
			ST_CLD: begin
				rx_q  <= rd_x;
				ry_q  <= rd_y;
				dqx_q <= DIFF_W'(ex_q) - DIFF_W'(px_q);
				dqy_q <= DIFF_W'(ey_q) - DIFF_W'(py_q);
				drx_q <= DIFF_W'(rd_x) - DIFF_W'(px_q);
				dry_q <= DIFF_W'(rd_y) - DIFF_W'(py_q);
			end
			ST_CMP: begin
				prod_q <= mul_p;
				case (step_q)
					3'd1: cross_q <= ACC_W'(prod_q);
					3'd2: cross_q <= cross_q - ACC_W'(prod_q);
					3'd3: dist_q  <= ACC_W'(prod_q);
					3'd4: dist_q  <= dist_q + ACC_W'(prod_q);
					3'd5: dist_q  <= dist_q - ACC_W'(prod_q);
					3'd6: begin
						if (take_r) begin
							ex_q <= rx_q;
							ey_q <= ry_q;
						end
					end
					default: ;
				endcase
			end
			ST_VEND: begin
				px_q <= ex_q;
				py_q <= ey_q;
			end
			default: ;
		endcase
	end

	// Breakpoint datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ERD1: begin
				x0_q <= hd_x;
				y0_q <= hd_y;
			end
			ST_ERD2: begin
				dx_q <= DIFF_W'(hd_x) - DIFF_W'(x0_q);
				dy_q <= DIFF_W'(hd_y) - DIFF_W'(y0_q);
			end
			ST_DIV: begin
				if (dx_q == '0) begin
					if (dy_q == '0) begin
						slope_q <= '0;
					end else begin
						slope_q <= dy_q[DIFF_W-1] ? SAT_MIN : SAT_MAX;
					end
				end
			end
			ST_DWT: begin
				if (div_rsp.done) begin
					slope_q <= slope_sat;
				end
			end
			ST_MUL: oprod_q <= slope_q * x0_q;
			default: ;
		endcase
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OFF) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_OFF) && out_free) begin
			out_data_q <= {offset_sat, slope_q};
			out_last_q <= ((k_q + 2'd2) == h_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_scnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= CNT_W'(MAX_POINTS))
		else $error("sample count exceeds store depth");

	a_hull_range: assert property (@(posedge clk) disable iff (!arst_n)
		h_q <= CNT_W'(MAX_POINTS))
		else $error("hull count exceeds store depth");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_DWT))
		else $error("divider running outside its wait state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OFF) && out_valid_q && !m_tready |=> (state_q == ST_OFF))
		else $error("breakpoint left before the output register was free");
`endif

endmodule

/* rtl/lec_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lec_ram #(
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [(1 << AW)];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; read data is registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lec_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module lec_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lec_pkg::lec_div_req_t          req,
	input  logic [lec_pkg::DIVD_W-1:0]     dividend,
	input  logic [lec_pkg::DIFF_W-1:0]     divisor,
	output lec_pkg::lec_div_rsp_t          rsp,
	output logic [lec_pkg::DIVD_W-1:0]     quotient
);
	import lec_pkg::*;

	logic [DIFF_W:0]   rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIFF_W:0]   shifted;
	logic [DIFF_W+1:0] trial;

	// Shift in the next dividend bit and try a subtraction.
	assign shifted = {rem_q[DIFF_W-1:0], quo_q[DIVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[DIFF_W+1]) begin
				rem_q <= trial[DIFF_W:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule
